// ===== rtl/assert_macros.svh =====
// Assertion shorthands used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define HMB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define HMB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/hmb_pkg.sv =====
package hmb_pkg;

    // Temperature format: signed, 0.05 degC per unit
    localparam int TEMP_W    = 14;
    localparam int SHIFT_W   = 3;
    localparam int BIN_OUT_W = 8;
    localparam int CNT_OUT_W = 11;

    // Bin centre arithmetic: offset and full-width sum
    localparam int OFF_W  = 16;
    localparam int HALF_W = 8;
    localparam int CTR_W  = 18;
    localparam logic signed [CTR_W-1:0] CTR_MAX = 18'sd8191;
    localparam logic signed [CTR_W-1:0] CTR_MIN = -18'sd8192;

    // Configuration bus
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        REG_LOW_LIMIT  = 2'd0,
        REG_HIGH_LIMIT = 2'd1,
        REG_BIN_SHIFT  = 2'd2
    } t_reg_idx;

    localparam logic signed [TEMP_W-1:0] LOW_LIMIT_RST  = 14'sd200;
    localparam logic signed [TEMP_W-1:0] HIGH_LIMIT_RST = 14'sd1000;
    localparam logic [SHIFT_W-1:0]       BIN_SHIFT_RST  = 3'd2;

    // Per-sample control flags travelling with the bin index
    typedef struct packed {
        logic hit;   // sample lies within the limits
        logic last;  // final pixel of the frame
    } t_bin_flags;

endpackage

// ===== rtl/hmb_count_ram.sv =====
module hmb_count_ram
    import hmb_pkg::*;
#(
    parameter int DEPTH = 200,
    parameter int AW    = 8,
    parameter int DW    = 11
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, old data on a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/hmb_bin_calc.sv =====
module hmb_bin_calc
    import hmb_pkg::*;
#(
    parameter int NUM_BINS = 200,
    parameter int BIN_W    = 8
) (
    input  logic signed [TEMP_W-1:0] i_sample,
    input  logic                     i_last,
    input  logic signed [TEMP_W-1:0] i_low_limit,
    input  logic signed [TEMP_W-1:0] i_high_limit,
    input  logic [SHIFT_W-1:0]       i_bin_shift,
    output logic [BIN_W-1:0]         o_bin,
    output t_bin_flags               o_flags
);

    localparam logic [TEMP_W-1:0] LAST_BIN = TEMP_W'(NUM_BINS - 1);

    logic [TEMP_W:0]   diff_full;
    logic [TEMP_W-1:0] diff;
    logic [TEMP_W-1:0] shifted;

    // Offset from the low limit; never negative when the sample is in range
    assign diff_full = {i_sample[TEMP_W-1], i_sample} - {i_low_limit[TEMP_W-1], i_low_limit};
    assign diff      = diff_full[TEMP_W-1:0];
    assign shifted   = diff >> i_bin_shift;

    // Clamp far samples into the top bin
    assign o_bin = (shifted > LAST_BIN) ? LAST_BIN[BIN_W-1:0] : shifted[BIN_W-1:0];

    assign o_flags.hit  = (i_sample >= i_low_limit) && (i_sample <= i_high_limit);
    assign o_flags.last = i_last;

endmodule

// ===== rtl/hmb_mode_track.sv =====
module hmb_mode_track
    import hmb_pkg::*;
#(
    parameter int BIN_W = 8,
    parameter int CNT_W = 11
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_upd,
    input  t_bin_flags               i_flags,
    input  logic [BIN_W-1:0]         i_bin,
    input  logic [CNT_W-1:0]         i_cnt,
    input  logic signed [TEMP_W-1:0] i_low_limit,
    input  logic [SHIFT_W-1:0]       i_bin_shift,
    output logic [BIN_W-1:0]         o_mode_bin,
    output logic [CNT_W-1:0]         o_mode_count,
    output logic signed [TEMP_W-1:0] o_background
);

    logic [BIN_W-1:0] r_best_bin;
    logic [CNT_W-1:0] r_best_cnt;

    logic                    take;
    logic [BIN_W-1:0]        cur_bin;
    logic [CNT_W-1:0]        cur_cnt;
    logic [OFF_W-1:0]        off;
    logic [HALF_W-1:0]       half;
    logic signed [CTR_W-1:0] ctr;

    // Running argmax, lower index wins a tie
    assign take    = i_flags.hit && ((i_cnt > r_best_cnt) ||
                     ((i_cnt == r_best_cnt) && (i_bin <= r_best_bin)));
    assign cur_bin = take ? i_bin : r_best_bin;
    assign cur_cnt = take ? i_cnt : r_best_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_bin <= '0;
            r_best_cnt <= '0;
        end else if (i_upd) begin
            if (i_flags.last) begin
                r_best_bin <= '0;
                r_best_cnt <= '0;
            end else begin
                r_best_bin <= cur_bin;
                r_best_cnt <= cur_cnt;
            end
        end
    end

    // Bin centre: low + bin * width + width / 2, saturated to the sample range
    assign off  = OFF_W'(cur_bin) << i_bin_shift;
    assign half = (HALF_W'(1) << i_bin_shift) >> 1;
    assign ctr  = CTR_W'(i_low_limit) + signed'(CTR_W'(off)) + signed'(CTR_W'(half));

    always_comb begin
        priority if (ctr > CTR_MAX) begin
            o_background = CTR_MAX[TEMP_W-1:0];
        end else if (ctr < CTR_MIN) begin
            o_background = CTR_MIN[TEMP_W-1:0];
        end else begin
            o_background = ctr[TEMP_W-1:0];
        end
    end

    assign o_mode_bin   = cur_bin;
    assign o_mode_count = cur_cnt;

endmodule

// ===== rtl/histogram_mode_background_top.sv =====
// Histogram-mode background estimator. Each transfer carries one pixel
// temperature; samples within [low_limit, high_limit] are counted in bin
// (sample - low_limit) >> bin_shift, clamped to the top bin, and a bin count
// stops at MAX_PIXELS. The transfer marked last yields one result: the
// fullest bin (lowest index on a tie), its count and its centre temperature;
// then the histogram starts over. One sample per clock is sustained unless
// the input stalls: the count memory is read as a sample is taken and
// written back from the update stage, with the write of the sample ahead
// forwarded on a same-bin collision. The result register holds each result
// until taken. A per-bin flag register marks bins touched in the current
// frame, so the frame clear needs no pass over the memory. The input stalls
// only while a result is still waiting and the next frame's last sample is
// about to finish. Write the limits and shift only while no sample is in
// flight; counts already taken in a frame are kept.
module histogram_mode_background_top
    import hmb_pkg::*;
#(
    parameter int NUM_BINS   = 200,
    parameter int MAX_PIXELS = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Sample channel
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [TEMP_W-1:0] i_sample,
    input  logic                     i_last,
    // Result channel
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [TEMP_W-1:0] o_background,
    output logic [BIN_OUT_W-1:0]     o_mode_bin,
    output logic [CNT_OUT_W-1:0]     o_mode_count,
    // Configuration
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready
);

    localparam int BIN_W = $clog2(NUM_BINS);
    localparam int CNT_W = $clog2(MAX_PIXELS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PIXELS);

    // Configuration registers
    logic signed [TEMP_W-1:0] r_low_limit;
    logic signed [TEMP_W-1:0] r_high_limit;
    logic [SHIFT_W-1:0]       r_bin_shift;
    logic                     cfg_wr;
    t_reg_idx                 cfg_idx;

    // Front end
    logic             accept;
    logic [BIN_W-1:0] calc_bin;
    t_bin_flags       calc_flags;

    // Update stage
    logic             r_s1_valid;
    t_bin_flags       r_s1_flags;
    logic [BIN_W-1:0] r_s1_bin;
    logic             r_vld_q;
    logic             s1_fire;
    logic [CNT_W-1:0] ram_q;
    logic [CNT_W-1:0] old_cnt;
    logic [CNT_W-1:0] new_cnt;
    logic             cnt_we;

    // Write seen at the edge of this stage's read
    logic             r_fw_wr;
    logic             r_fw_clr;
    logic [BIN_W-1:0] r_fw_bin;
    logic [CNT_W-1:0] r_fw_cnt;

    // Bins touched in the current frame
    logic [NUM_BINS-1:0] r_valid;

    // Mode tracker outputs
    logic [BIN_W-1:0]         mt_bin;
    logic [CNT_W-1:0]         mt_cnt;
    logic signed [TEMP_W-1:0] mt_bg;

    // Output register
    logic                     r_out_valid;
    logic signed [TEMP_W-1:0] r_out_bg;
    logic [BIN_OUT_W-1:0]     r_out_bin;
    logic [CNT_OUT_W-1:0]     r_out_cnt;

    // Configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_limit  <= LOW_LIMIT_RST;
            r_high_limit <= HIGH_LIMIT_RST;
            r_bin_shift  <= BIN_SHIFT_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_LOW_LIMIT:  r_low_limit  <= signed'(pwdata[TEMP_W-1:0]);
                REG_HIGH_LIMIT: r_high_limit <= signed'(pwdata[TEMP_W-1:0]);
                REG_BIN_SHIFT:  r_bin_shift  <= pwdata[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_LOW_LIMIT:  prdata = DATA_W'(r_low_limit);
            REG_HIGH_LIMIT: prdata = DATA_W'(r_high_limit);
            REG_BIN_SHIFT:  prdata = DATA_W'(r_bin_shift);
            default:        prdata = '0;
        endcase
    end

    // Bin index of the incoming sample
    hmb_bin_calc #(
        .NUM_BINS (NUM_BINS),
        .BIN_W    (BIN_W)
    ) u_bin_calc (
        .i_sample     (i_sample),
        .i_last       (i_last),
        .i_low_limit  (r_low_limit),
        .i_high_limit (r_high_limit),
        .i_bin_shift  (r_bin_shift),
        .o_bin        (calc_bin),
        .o_flags      (calc_flags)
    );

    // Handshake: a last sample waits only while the output register is held
    assign s1_fire = r_s1_valid && (!r_s1_flags.last || !r_out_valid || i_ready);
    assign o_ready = !r_s1_valid || s1_fire;
    assign accept  = i_valid && o_ready;

    // Count memory, read on accept, written back from the update stage
    hmb_count_ram #(
        .DEPTH (NUM_BINS),
        .AW    (BIN_W),
        .DW    (CNT_W)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (r_s1_bin),
        .i_wdata (new_cnt),
        .i_re    (accept),
        .i_raddr (calc_bin),
        .o_rdata (ram_q)
    );

    // Stage register and forwarding capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fw_wr    <= 1'b0;
            r_fw_clr   <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
            r_fw_wr    <= cnt_we;
            r_fw_clr   <= s1_fire && r_s1_flags.last;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_flags <= calc_flags;
            r_s1_bin   <= calc_bin;
            r_vld_q    <= r_valid[calc_bin];
            r_fw_bin   <= r_s1_bin;
            r_fw_cnt   <= new_cnt;
        end
    end

    // Old count: cleared frame, forwarded write, or memory if touched this frame
    always_comb begin
        priority if (r_fw_clr) begin
            old_cnt = '0;
        end else if (r_fw_wr && (r_fw_bin == r_s1_bin)) begin
            old_cnt = r_fw_cnt;
        end else if (r_vld_q) begin
            old_cnt = ram_q;
        end else begin
            old_cnt = '0;
        end
    end

    // Saturating increment
    assign new_cnt = (old_cnt == MAX_CNT) ? old_cnt : old_cnt + CNT_W'(1);
    assign cnt_we  = s1_fire && r_s1_flags.hit;

    // Frame flags: set on write, all cleared after the last sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (s1_fire && r_s1_flags.last) begin
            r_valid <= '0;
        end else if (cnt_we) begin
            r_valid[r_s1_bin] <= 1'b1;
        end
    end

    // Running argmax and bin centre
    hmb_mode_track #(
        .BIN_W (BIN_W),
        .CNT_W (CNT_W)
    ) u_mode_track (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_upd        (s1_fire),
        .i_flags      (r_s1_flags),
        .i_bin        (r_s1_bin),
        .i_cnt        (new_cnt),
        .i_low_limit  (r_low_limit),
        .i_bin_shift  (r_bin_shift),
        .o_mode_bin   (mt_bin),
        .o_mode_count (mt_cnt),
        .o_background (mt_bg)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && r_s1_flags.last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1_flags.last) begin
            r_out_bg  <= mt_bg;
            r_out_bin <= BIN_OUT_W'(mt_bin);
            r_out_cnt <= CNT_OUT_W'(mt_cnt);
        end
    end

    assign o_valid      = r_out_valid;
    assign o_background = r_out_bg;
    assign o_mode_bin   = r_out_bin;
    assign o_mode_count = r_out_cnt;

endmodule

// ===== rtl/hmb_checker.sv =====
`include "assert_macros.svh"

module hmb_checker
    import hmb_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_valid,
    input logic                     o_ready,
    input logic                     i_last,
    input logic                     o_valid,
    input logic                     i_ready,
    input logic signed [TEMP_W-1:0] o_background,
    input logic [BIN_OUT_W-1:0]     o_mode_bin,
    input logic [CNT_OUT_W-1:0]     o_mode_count
);

    // A waiting result holds until taken
    `HMB_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_background) && $stable(o_mode_bin) && $stable(o_mode_count), "result changed while stalled")

    // A fresh result follows a last-sample transfer through the update stage and the result register
    `HMB_ASSERT_IMP(a_out_after_last, i_clk, i_rst_n, $rose(o_valid), $past(i_valid && o_ready && i_last, 2), "result without a last sample")

    // An empty frame reports bin zero
    `HMB_ASSERT_IMP(a_empty_bin0, i_clk, i_rst_n, o_valid && (o_mode_count == 11'd0), o_mode_bin == 8'd0, "empty frame with nonzero bin")

    // The input only stalls behind a waiting result
    `HMB_ASSERT_IMP(a_ready_when_free, i_clk, i_rst_n, !o_valid, o_ready, "input stalled with no result pending")

endmodule

bind histogram_mode_background_top hmb_checker u_hmb_checker (.*);
